// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; ASSERT_CLK expects a clock named clk and a reset named rst, ASSERT_ALWAYS only the clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge and disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/srxc_pkg.sv -----
// Shared types, codes and sizes for the sentence receiver with XOR check.
// Depends on nothing; every other module file imports it.
package srxc_pkg;

  localparam int unsigned LINE_CAPACITY = 128;
  localparam int unsigned AddrW = $clog2(LINE_CAPACITY);
  localparam int unsigned PosW = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned IndexW = 7;
  localparam int unsigned LenW = 7;
  localparam int unsigned IdxExtW = (AddrW > IndexW) ? AddrW : IndexW;
  localparam int unsigned PosExtW = (PosW > LenW) ? PosW : LenW;
  localparam int unsigned MinLineLen = 5;

  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_READY   = 3'd1;
  localparam logic [2:0] EV_DROP    = 3'd2;
  localparam logic [2:0] EV_READ    = 3'd3;
  localparam logic [2:0] EV_IGNORED = 3'd4;

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        rx_byte;
    logic [IndexW-1:0] read_index;
  } srxc_in_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic [LenW-1:0] line_length;
    logic            checksum_ok;
    logic [7:0]      read_data;
  } srxc_out_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } srxc_wr_t;

endpackage

// ----- sv/srxc_line_ram.sv -----
// Line store: single write port, single registered read port.
// Depends on srxc_pkg for the depth and address width.
module srxc_line_ram (
  input  logic                     clk,
  input  srxc_pkg::srxc_wr_t       wr,
  input  logic                     rd_en,
  input  logic [srxc_pkg::AddrW-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  import srxc_pkg::*;

  logic [7:0] mem [LINE_CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/srxc_frame_ctrl.sv -----
// Framing state, checksum tracking and result formation for one item.
// Depends on srxc_pkg; drives the write port of the line store.
module srxc_frame_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  srxc_pkg::srxc_in_t  item,
  input  logic                in_range,
  input  logic [7:0]          stored_byte,
  output srxc_pkg::srxc_out_t res,
  output srxc_pkg::srxc_wr_t  wr
);
  import srxc_pkg::*;

  logic            in_frame, in_frame_next;
  logic            line_ready, line_ready_next;
  logic [PosW-1:0] write_position, write_position_next;
  logic [7:0]      running_xor, running_xor_next;
  logic            star_seen, star_seen_next;
  logic [1:0]      digits_after_star, digits_after_star_next;
  logic [7:0]      received_sum, received_sum_next;
  logic            digit_bad, digit_bad_next;

  logic [PosExtW-1:0] pos_ext;
  logic [4:0]         hex_val;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 5'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 5'(c - 8'h57);
    end
    return v;
  endfunction

  assign pos_ext = PosExtW'(write_position);
  assign hex_val = hex_value(item.rx_byte);

  always_comb begin
    in_frame_next          = in_frame;
    line_ready_next        = line_ready;
    write_position_next    = write_position;
    running_xor_next       = running_xor;
    star_seen_next         = star_seen;
    digits_after_star_next = digits_after_star;
    received_sum_next      = received_sum;
    digit_bad_next         = digit_bad;
    res = '0;
    wr  = '0;
    case (item.operation)
      OP_FEED: begin
        if (line_ready) begin
          res.event_res = EV_IGNORED;
        end else if (item.rx_byte == CHAR_DOLLAR) begin
          in_frame_next          = 1'b1;
          wr.en                  = step;
          wr.addr                = '0;
          wr.data                = CHAR_DOLLAR;
          write_position_next    = PosW'(1);
          running_xor_next       = '0;
          star_seen_next         = 1'b0;
          digits_after_star_next = '0;
          received_sum_next      = '0;
          digit_bad_next         = 1'b0;
        end else if (!in_frame) begin
          res.event_res = EV_NONE;
        end else if (item.rx_byte == CHAR_NEWLINE) begin
          if (write_position < PosW'(LINE_CAPACITY)) begin
            line_ready_next   = 1'b1;
            res.event_res     = EV_READY;
            res.line_length   = pos_ext[LenW-1:0];
            res.checksum_ok   = (write_position >= PosW'(MinLineLen)) && star_seen &&
                                (digits_after_star == 2'd2) && !digit_bad &&
                                (received_sum == running_xor);
          end else begin
            write_position_next = '0;
            in_frame_next       = 1'b0;
            res.event_res       = EV_DROP;
          end
        end else if (write_position >= PosW'(LINE_CAPACITY)) begin
          write_position_next = '0;
          in_frame_next       = 1'b0;
          res.event_res       = EV_DROP;
        end else begin
          wr.en               = step;
          wr.addr             = write_position[AddrW-1:0];
          wr.data             = item.rx_byte;
          write_position_next = write_position + PosW'(1);
          if (!star_seen) begin
            if (item.rx_byte == CHAR_STAR) begin
              star_seen_next = 1'b1;
            end else begin
              running_xor_next = running_xor ^ item.rx_byte;
            end
          end else if (digits_after_star != 2'd2) begin
            // A bad digit counts as zero but poisons the verdict.
            digit_bad_next         = digit_bad | hex_val[4];
            received_sum_next      = {received_sum[3:0],
                                      hex_val[4] ? 4'h0 : hex_val[3:0]};
            digits_after_star_next = digits_after_star + 2'd1;
          end
        end
      end
      OP_READ: begin
        res.event_res = EV_READ;
        res.read_data = in_range ? stored_byte : 8'h00;
      end
      OP_RELEASE: begin
        if (line_ready) begin
          line_ready_next     = 1'b0;
          in_frame_next       = 1'b0;
          write_position_next = '0;
        end
      end
      default: begin
        res.event_res = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      line_ready        <= 1'b0;
      write_position    <= '0;
      running_xor       <= '0;
      star_seen         <= 1'b0;
      digits_after_star <= '0;
      received_sum      <= '0;
      digit_bad         <= 1'b0;
    end else if (step) begin
      in_frame          <= in_frame_next;
      line_ready        <= line_ready_next;
      write_position    <= write_position_next;
      running_xor       <= running_xor_next;
      star_seen         <= star_seen_next;
      digits_after_star <= digits_after_star_next;
      received_sum      <= received_sum_next;
      digit_bad         <= digit_bad_next;
    end
  end

endmodule

// ----- sv/sentence_receiver_xor_check.sv -----
// Throughput, while results are not stalled: one item per cycle; the store's registered read
// is issued as the item is taken. Items pass the input register, then the result register.
// A store write from the item ahead is forwarded to a read that is taken at the same edge.
// Reset (rst, synchronous, active high) empties both stages and clears framing and checksum
// state; the line store itself keeps its contents and needs no clearing pass.
module sentence_receiver_xor_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  srxc_pkg::srxc_in_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output srxc_pkg::srxc_out_t result
);
  import srxc_pkg::*;

  logic               accept, out_free, step;
  logic               s1_valid;
  srxc_in_t           s1_item;
  logic               s1_in_range;
  logic [IdxExtW-1:0] idx_ext;
  logic [AddrW-1:0]   rd_addr;
  logic [7:0]         ram_rd_data;
  logic               fwd_hit;
  logic [7:0]         fwd_data;
  logic [7:0]         stored_byte;
  srxc_out_t          ctrl_res;
  srxc_wr_t           wr;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;
  assign step       = s1_valid && out_free;

  assign idx_ext     = IdxExtW'(item.read_index);
  assign rd_addr     = idx_ext[AddrW-1:0];
  assign stored_byte = fwd_hit ? fwd_data : ram_rd_data;

  srxc_line_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  srxc_frame_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (s1_item),
    .in_range    (s1_in_range),
    .stored_byte (stored_byte),
    .res         (ctrl_res),
    .wr          (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  // The store read sees old data when the item ahead writes the same entry at this edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= item;
      s1_in_range <= (IdxExtW+1)'(idx_ext) < (IdxExtW+1)'(LINE_CAPACITY);
      fwd_hit     <= wr.en && (wr.addr == rd_addr);
      fwd_data    <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= ctrl_res;
    end
  end

endmodule

// ----- sv/srxc_checker.sv -----
// Port-level checks for the sentence receiver, bound to the top level.
// Depends on srxc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srxc_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input srxc_pkg::srxc_in_t  item,
  input logic                result_valid,
  input logic                result_stall,
  input srxc_pkg::srxc_out_t result
);
  import srxc_pkg::*;

  logic item_seen;
  assign item_seen = item_valid && !item_stall && (item.operation <= OP_RELEASE);

  `ASSERT_CLK(a_result_held,
    result_valid && result_stall |=> result_valid && $stable(result),
    "stalled result changed")
  `ASSERT_CLK(a_len_only_ready,
    result_valid && (result.event_res != EV_READY) |->
      (result.line_length == '0) && !result.checksum_ok,
    "length or verdict without a ready line")
  `ASSERT_CLK(a_data_only_read,
    result_valid && (result.event_res != EV_READ) |-> (result.read_data == 8'h00),
    "read data outside a read result")
  `ASSERT_CLK(a_ok_needs_len,
    result_valid && result.checksum_ok |-> (result.line_length >= LenW'(MinLineLen)),
    "checksum passed on a short line")
  `ASSERT_ALWAYS(a_reset_empty,
    $past(rst) && item_seen |-> !result_valid,
    "result shown right after reset")

endmodule

bind sentence_receiver_xor_check srxc_checker u_srxc_checker (.*);

// ----- dv/sentence_receiver_xor_check_tb.sv -----
// Self-checking testbench for the sentence receiver with XOR checksum.
// Depends on srxc_pkg and sentence_receiver_xor_check; a built-in predictor tracks
// framing, the line store and the checksum verdict for every item sent.
`timescale 1ns / 1ps

module sentence_receiver_xor_check_tb;
  import srxc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_ITEMS = 300;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 50;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  srxc_in_t  item;
  logic      result_valid;
  logic      result_stall;
  srxc_out_t result;

  sentence_receiver_xor_check dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  srxc_out_t sentence_expect[$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        calm = 1'b0;
  bit        hold_off_req = 1'b0;

  // Predicted receiver state.
  bit                frame_open = 1'b0;
  bit                ready_held = 1'b0;
  logic [7:0]        wr_pos = '0;
  logic [LenW-1:0]   held_len = '0;
  logic [7:0]        line_mem [LINE_CAPACITY];
  bit                line_written [LINE_CAPACITY];
  logic [7:0]        xor_acc = '0;
  bit                star_flag = 1'b0;
  logic [1:0]        digit_cnt = '0;
  logic [7:0]        sum_rx = '0;
  bit                bad_digit = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic srxc_out_t predict_sentence(input srxc_in_t it);
    srxc_out_t  r;
    logic [7:0] b;
    logic [4:0] nib;
    r = '0;
    b = it.rx_byte;
    case (it.operation)
      OP_FEED: begin
        if (ready_held) begin
          r.event_res = EV_IGNORED;
        end else if (b == CHAR_DOLLAR) begin
          frame_open = 1'b1;
          line_mem[0] = CHAR_DOLLAR;
          line_written[0] = 1'b1;
          wr_pos = 8'd1;
          xor_acc = '0;
          star_flag = 1'b0;
          digit_cnt = '0;
          sum_rx = '0;
          bad_digit = 1'b0;
        end else if (!frame_open) begin
          r.event_res = EV_NONE;
        end else if (b == CHAR_NEWLINE) begin
          if (wr_pos < LINE_CAPACITY) begin
            held_len = wr_pos[LenW-1:0];
            ready_held = 1'b1;
            r.event_res = EV_READY;
            r.line_length = held_len;
            r.checksum_ok = (wr_pos >= MinLineLen) && star_flag && (digit_cnt == 2'd2) &&
                            !bad_digit && (sum_rx == xor_acc);
          end else begin
            wr_pos = '0;
            frame_open = 1'b0;
            r.event_res = EV_DROP;
          end
        end else if (wr_pos >= LINE_CAPACITY) begin
          wr_pos = '0;
          frame_open = 1'b0;
          r.event_res = EV_DROP;
        end else begin
          line_mem[wr_pos[AddrW-1:0]] = b;
          line_written[wr_pos[AddrW-1:0]] = 1'b1;
          wr_pos = wr_pos + 8'd1;
          if (!star_flag) begin
            if (b == CHAR_STAR) star_flag = 1'b1;
            else xor_acc = xor_acc ^ b;
          end else if (digit_cnt < 2'd2) begin
            // Only the first two bytes after the star count; a non-hex byte
            // spoils the verdict but still shifts in a zero nibble.
            if (b >= "0" && b <= "9") nib = 5'(b - "0");
            else if (b >= "A" && b <= "F") nib = 5'(b - "A" + 10);
            else if (b >= "a" && b <= "f") nib = 5'(b - "a" + 10);
            else nib = 5'd16;
            if (nib[4]) begin
              bad_digit = 1'b1;
              nib = '0;
            end
            sum_rx = {sum_rx[3:0], nib[3:0] & NIBBLE_MASK[3:0]};
            digit_cnt = digit_cnt + 2'd1;
          end
        end
      end
      OP_READ: begin
        r.event_res = EV_READ;
        r.read_data = line_mem[it.read_index];
      end
      OP_RELEASE: begin
        if (ready_held) begin
          ready_held = 1'b0;
          frame_open = 1'b0;
          wr_pos = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic srxc_in_t make_item(input logic [1:0] op, input logic [7:0] b,
                                         input logic [IndexW-1:0] idx);
    srxc_in_t it;
    it.operation = op;
    it.rx_byte = b;
    it.read_index = idx;
    return it;
  endfunction

  // Only entries that have been written are ever read back.
  function automatic logic [IndexW-1:0] pick_written_index();
    logic [IndexW-1:0] idx;
    for (int k = 0; k < 32; k++) begin
      idx = IndexW'($urandom_range(0, LINE_CAPACITY - 1));
      if (line_written[idx]) return idx;
    end
    return '0;
  endfunction

  task automatic send_item(input srxc_in_t it);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sentence_expect.push_back(predict_sentence(it));
    items_sent++;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    send_item(make_item(OP_FEED, b, IndexW'($urandom)));
  endtask

  task automatic read_back(input logic [IndexW-1:0] idx);
    send_item(make_item(OP_READ, 8'($urandom), idx));
  endtask

  task automatic release_line();
    send_item(make_item(OP_RELEASE, 8'($urandom), IndexW'($urandom)));
  endtask

  task automatic feed_text(input string s);
    for (int k = 0; k < s.len(); k++) feed_byte(s[k]);
  endtask

  task automatic feed_sentence(input string body, input bit lower);
    logic [7:0] x;
    x = '0;
    for (int k = 0; k < body.len(); k++) x = x ^ body[k];
    if (lower) feed_text($sformatf("$%s*%02x\n", body, x));
    else feed_text($sformatf("$%s*%02X\n", body, x));
  endtask

  // Items with nothing to act on: no frame open and no line held.
  task automatic test_idle_items();
    release_line();
    send_item(make_item(OP_UNUSED, 8'hFF, 7'h7F));
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_byte(CHAR_NEWLINE);
    feed_byte(CHAR_STAR);
  endtask

  task automatic test_good_sentences();
    feed_sentence("GPGLL,49,N", 1'b0);
    read_back(7'd0);
    read_back(7'd3);
    read_back(7'd13);
    // A held line ignores everything fed to it, a dollar sign included.
    feed_byte(CHAR_DOLLAR);
    feed_byte(8'hFF);
    release_line();
    release_line();
    feed_sentence("gpzda,z", 1'b1);
    release_line();
    feed_text("$A*41\n");
    release_line();
    feed_text("$AB*03xyz\n");
    read_back(7'd7);
    release_line();
  endtask

  task automatic test_bad_sentences();
    feed_text("$AB*00\n");
    release_line();
    feed_text("$ABC\n");
    release_line();
    feed_text("$AB*0\n");
    release_line();
    feed_text("$AB*0G\n");
    release_line();
    feed_text("$AB**3\n");
    release_line();
    feed_text("$*00\n");
    release_line();
    feed_text("$\n");
    release_line();
    // A dollar sign in the middle of a frame starts over.
    feed_text("$XY*00$CD*07\n");
    release_line();
    feed_byte(CHAR_DOLLAR);
    feed_byte(8'h80);
    feed_byte(8'hFE);
    feed_text("*7E\n");
    read_back(7'd1);
    release_line();
  endtask

  task automatic test_line_overflow();
    logic [7:0] x;
    logic [7:0] c;
    // Longest line that fits, with a valid checksum at its tail.
    x = '0;
    feed_byte(CHAR_DOLLAR);
    for (int k = 0; k < LINE_CAPACITY - 5; k++) begin
      c = 8'("A" + k % 26);
      x = x ^ c;
      feed_byte(c);
    end
    feed_text($sformatf("*%02X\n", x));
    read_back(7'd126);
    release_line();
    // A full store abandons the frame on a newline or on any other byte.
    feed_byte(CHAR_DOLLAR);
    for (int k = 1; k < LINE_CAPACITY; k++) feed_byte(8'("a" + k % 26));
    feed_byte(CHAR_NEWLINE);
    read_back(7'd127);
    read_back(7'd64);
    feed_byte(CHAR_DOLLAR);
    for (int k = 1; k < LINE_CAPACITY; k++) feed_byte(8'h80 | 8'(k));
    feed_byte("Z");
    feed_byte(CHAR_NEWLINE);
    read_back(7'd127);
  endtask

  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    repeat (4) begin
      feed_sentence("GPRMC,12,A", 1'b0);
      read_back(pick_written_index());
      release_line();
    end
  endtask

  task automatic random_sentence();
    int         len;
    logic [7:0] c;
    logic [7:0] x;
    logic [7:0] sum_sent;
    string      digits;
    x = '0;
    feed_byte(CHAR_DOLLAR);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 130)
                                       : $urandom_range(0, 12);
    repeat (len) begin
      do begin
        c = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
      end while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_NEWLINE);
      x = x ^ c;
      feed_byte(c);
    end
    if ($urandom_range(0, 7) != 0) begin
      feed_byte(CHAR_STAR);
      sum_sent = ($urandom_range(0, 7) == 0) ? 8'($urandom) : x;
      digits = $sformatf("%02X", sum_sent);
      for (int k = 0; k < 2; k++) begin
        c = digits[k];
        if (c >= "A" && $urandom_range(0, 1)) c = c + 8'h20;
        if ($urandom_range(0, 15) == 0) c = 8'($urandom);
        feed_byte(c);
      end
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) feed_byte(8'($urandom_range(32, 126)));
    end
    if ($urandom_range(0, 15) != 0) feed_byte(CHAR_NEWLINE);
    repeat ($urandom_range(0, 3)) read_back(pick_written_index());
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) feed_byte(8'($urandom));
    if ($urandom_range(0, 7) != 0) release_line();
  endtask

  task automatic random_noise();
    logic [1:0] op;
    repeat ($urandom_range(1, 6)) begin
      op = 2'($urandom_range(0, 3));
      if (op == OP_READ) read_back(pick_written_index());
      else send_item(make_item(op, 8'($urandom), IndexW'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - first >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      else if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 3) != 0) random_sentence();
      else random_noise();
    end
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst_left;
    burst_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        burst_left = 0;
      end else if (burst_left > 0) begin
        result_stall <= 1'b1;
        burst_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        burst_left = $urandom_range(1, 8) - 1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    srxc_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (sentence_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got ev %0d len %0d ok %0d data %02h",
                   $time, result.event_res, result.line_length, result.checksum_ok,
                   result.read_data);
      end else begin
        want = sentence_expect.pop_front();
        if (result.event_res !== want.event_res || result.line_length !== want.line_length ||
            result.checksum_ok !== want.checksum_ok || result.read_data !== want.read_data) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: mismatch, expected ev %0d len %0d ok %0d data %02h,",
                      " got ev %0d len %0d ok %0d data %02h"},
                     $time, want.event_res, want.line_length, want.checksum_ok,
                     want.read_data, result.event_res, result.line_length,
                     result.checksum_ok, result.read_data);
        end
      end
    end
  end

  // Ends the run when neither side has moved an item for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_good_sentences();
    test_bad_sentences();
    test_line_overflow();
    test_output_hold_off();
    test_random_traffic();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sentence_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && sentence_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
